>>> design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/rtmid_pkg.sv
// Types and constants for the record table block.
package rtmid_pkg;

    // Table size; slots are indexed from zero
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Fixed field widths
    localparam int SLOT_W = 6;
    localparam int CNT_W  = 7;
    localparam int LOW_W  = 64;
    localparam int HIGH_W = 16;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_LIST   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2,
        ST_EMIT = 2'd3
    } t_status;

    // One stored record
    typedef struct packed {
        logic [HIGH_W-1:0] key_high;
        logic [LOW_W-1:0]  key_low;
        logic [HIGH_W-1:0] surname_high;
        logic [LOW_W-1:0]  surname_low;
        logic [HIGH_W-1:0] phone_high;
        logic [LOW_W-1:0]  phone_low;
    } t_rec;

    // Input beat
    typedef struct packed {
        t_op               operation;
        logic [LOW_W-1:0]  key_low;
        logic [HIGH_W-1:0] key_high;
        logic [LOW_W-1:0]  surname_low;
        logic [HIGH_W-1:0] surname_high;
        logic [LOW_W-1:0]  phone_low;
        logic [HIGH_W-1:0] phone_high;
    } t_in;

    // Result beat
    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  removed_count;
        logic [LOW_W-1:0]  out_key_low;
        logic [HIGH_W-1:0] out_key_high;
        logic [LOW_W-1:0]  out_surname_low;
        logic [HIGH_W-1:0] out_surname_high;
        logic [LOW_W-1:0]  out_phone_low;
        logic [HIGH_W-1:0] out_phone_high;
        logic              last;
    } t_out;

endpackage

>>> design/rtmid_ram.sv
// Generic single-port RAM with registered read.
module rtmid_ram #(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read; read data holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/record_table_match_insert_delete.sv
// Record table: first-free insert, exact-name delete, search and list.
//
//  channel | direction | signals                           | beat
//  input   | in        | i_in_valid, o_in_stall, i_in      | one operation
//  output  | out       | o_out_valid, i_out_stall, o_out   | one result, last on final
//
// Insert walks the used bits one slot a cycle until it finds a free slot or the end.
// Delete, search and list read the record RAM one slot a cycle through its
// single port, prefetching the next slot, unless a stalled output holds the scan.
// The next item is taken once the final result beat of the current one is registered.
// Reset clears the per-slot used bits at once; delete, search and list skip an unused slot.
module record_table_match_insert_delete
    import rtmid_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_CHECK,
        S_FIN
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    t_state               r_state;
    t_op                  r_op;
    logic [LOW_W-1:0]     r_key_low;
    logic [HIGH_W-1:0]    r_key_high;
    logic [LOW_W-1:0]     r_sur_low;
    logic [HIGH_W-1:0]    r_sur_high;
    logic [LOW_W-1:0]     r_ph_low;
    logic [HIGH_W-1:0]    r_ph_high;
    logic [IDX_W-1:0]     r_idx;
    logic [CNT_W-1:0]     r_count;
    logic [TABLE_DEPTH-1:0] r_used;
    logic                 r_held_valid;
    t_rec                 r_held;
    logic [IDX_W-1:0]     r_held_idx;
    logic                 r_out_valid;
    t_out                 r_out;

    logic                 accept;
    logic                 out_free;
    logic                 cur_used;
    logic                 key_eq;
    logic                 hit;
    logic                 is_end;
    logic                 step;
    logic                 ram_we;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_addr;
    t_rec                 ram_wrec;
    logic [$bits(t_rec)-1:0] ram_q;
    t_rec                 rd_rec;

    // Result beat builders
    function automatic t_out f_status(t_status st, logic [IDX_W-1:0] idx,
                                      logic [CNT_W-1:0] cnt);
        t_out o;
        o               = '0;
        o.status        = st;
        o.slot          = SLOT_W'(idx);
        o.removed_count = cnt;
        o.last          = 1'b1;
        return o;
    endfunction

    function automatic t_out f_emit(t_rec rec, logic [IDX_W-1:0] idx, logic lst);
        t_out o;
        o                  = '0;
        o.status           = ST_EMIT;
        o.slot             = SLOT_W'(idx);
        o.out_key_low      = rec.key_low;
        o.out_key_high     = rec.key_high;
        o.out_surname_low  = rec.surname_low;
        o.out_surname_high = rec.surname_high;
        o.out_phone_low    = rec.phone_low;
        o.out_phone_high   = rec.phone_high;
        o.last             = lst;
        return o;
    endfunction

    // Record store
    rtmid_ram #(
        .WIDTH ($bits(t_rec)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wrec),
        .o_rdata (ram_q)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Slot compare: unused slots are masked by their used bit, so they never match a key
    assign rd_rec   = t_rec'(ram_q);
    assign cur_used = r_used[r_idx];
    assign key_eq   = ({rd_rec.key_high, rd_rec.key_low} == {r_key_high, r_key_low});
    assign hit      = cur_used && ((r_op == OP_LIST) || key_eq);
    assign is_end   = (r_idx == LAST_IDX);

    assign ram_wrec = '{key_high: r_key_high, key_low: r_key_low,
                        surname_high: r_sur_high, surname_low: r_sur_low,
                        phone_high: r_ph_high, phone_low: r_ph_low};

    // RAM port control and scan step
    always_comb begin
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        ram_addr = r_idx;
        step     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_in.operation != OP_INSERT)) begin
                    ram_re   = 1'b1;
                    ram_addr = '0;
                end
            end
            S_INS: begin
                ram_we = !cur_used && out_free;
            end
            S_CHECK: begin
                // a second emitted record pushes the held one out
                step = !(hit && (r_op != OP_DELETE) && r_held_valid && !out_free);
                if (step && !is_end) begin
                    ram_re   = 1'b1;
                    ram_addr = r_idx + IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    // Sequencer, table state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_held_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op         <= i_in.operation;
                        r_key_low    <= i_in.key_low;
                        r_key_high   <= i_in.key_high;
                        r_sur_low    <= i_in.surname_low;
                        r_sur_high   <= i_in.surname_high;
                        r_ph_low     <= i_in.phone_low;
                        r_ph_high    <= i_in.phone_high;
                        r_idx        <= '0;
                        r_count      <= '0;
                        r_held_valid <= 1'b0;
                        r_state      <= (i_in.operation == OP_INSERT) ? S_INS : S_CHECK;
                    end
                end
                S_INS: begin
                    if (!cur_used) begin
                        if (out_free) begin
                            // an all-zero name leaves the slot free
                            r_used[r_idx] <= ({r_key_high, r_key_low} != '0);
                            r_out         <= f_status(ST_DONE, r_idx, '0);
                            r_out_valid   <= 1'b1;
                            r_state       <= S_IDLE;
                        end
                    end else if (is_end) begin
                        if (out_free) begin
                            r_out       <= f_status(ST_FULL, '0, '0);
                            r_out_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_CHECK: begin
                    if (step) begin
                        if (hit) begin
                            if (r_op == OP_DELETE) begin
                                r_used[r_idx] <= 1'b0;
                                r_count       <= r_count + CNT_W'(1);
                            end else begin
                                if (r_held_valid) begin
                                    r_out       <= f_emit(r_held, r_held_idx, 1'b0);
                                    r_out_valid <= 1'b1;
                                end
                                r_held       <= rd_rec;
                                r_held_idx   <= r_idx;
                                r_held_valid <= 1'b1;
                            end
                        end
                        if (is_end) begin
                            r_state <= S_FIN;
                        end else begin
                            r_idx <= r_idx + IDX_W'(1);
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        if (r_op == OP_DELETE) begin
                            r_out <= (r_count == '0) ? f_status(ST_NONE, '0, '0)
                                                     : f_status(ST_DONE, '0, r_count);
                        end else if (r_held_valid) begin
                            r_out <= f_emit(r_held, r_held_idx, 1'b1);
                        end else begin
                            r_out <= f_status(ST_NONE, '0, '0);
                        end
                        r_held_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> design/rtmid_checker.sv
// Port-level checks for the record table, bound to the top level.
`include "assert_macros.svh"

module rtmid_checker
    import rtmid_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out
);

    // A stalled result beat holds
    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out), "stalled result changed")

    // An accepted operation keeps the input stalled while it scans
    `ASSERT_RST(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall, "input not stalled after accept")

    // Only emitted records may be non-final; status beats always close an item
    `ASSERT_RST(a_status_last, i_clk, i_rst_n, o_out_valid && (o_out.status != ST_EMIT) |-> o_out.last, "status beat without last")

    // Full and not-found beats carry no slot, count or record
    `ASSERT_RST(a_empty_fields, i_clk, i_rst_n, o_out_valid && ((o_out.status == ST_FULL) || (o_out.status == ST_NONE)) |-> (o_out.slot == '0) && (o_out.removed_count == '0) && (o_out.out_key_low == '0), "stray fields on status beat")

    // No result straight out of reset
    `ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind record_table_match_insert_delete rtmid_checker u_rtmid_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

>>> verif/tb_record_table_match_insert_delete.sv
// Self-checking testbench for the record table: insert, delete, search and list beats.
`timescale 1ns / 100ps

module tb_record_table_match_insert_delete
    import rtmid_pkg::*;
();

    localparam int HOLD_CYCLES  = 400;
    localparam int NAME_POOL    = 8;
    localparam int RUN_LIMIT_NS = 20_000_000;

    // Shadow copy of the record store and the result beats it still owes
    class record_book;
        t_rec        entries[TABLE_DEPTH];
        t_out        pending_q[$];
        int unsigned errors;
        int unsigned ops_taken;
        int unsigned beats_checked;
        int unsigned emitted;
        int unsigned full_hits;
        int unsigned miss_hits;
        int unsigned max_removed;

        function new();
            foreach (entries[s]) entries[s] = '0;
            errors        = 0;
            ops_taken     = 0;
            beats_checked = 0;
            emitted       = 0;
            full_hits     = 0;
            miss_hits     = 0;
            max_removed   = 0;
        endfunction

        function bit occupied(int s);
            return (entries[s].key_low != '0) || (entries[s].key_high != '0);
        endfunction

        function int lowest_used();
            int s;
            int found;
            found = -1;
            for (s = TABLE_DEPTH - 1; s >= 0; s--)
                if (occupied(s)) found = s;
            return found;
        endfunction

        // Apply one accepted operation and queue the beats it must produce
        function void take_request(t_in req);
            t_out beat;
            t_out held;
            bit   key_zero;
            bit   placed;
            bit   have_held;
            bit   hit;
            int   s;
            int   removed;
            key_zero  = (req.key_low == '0) && (req.key_high == '0);
            placed    = 1'b0;
            have_held = 1'b0;
            removed   = 0;
            held      = '0;
            beat      = '0;
            beat.last = 1'b1;
            ops_taken++;
            case (req.operation)
                OP_INSERT: begin
                    beat.status = ST_FULL;
                    for (s = 0; s < TABLE_DEPTH; s++) begin
                        if (!placed && !occupied(s)) begin
                            entries[s].key_low      = req.key_low;
                            entries[s].key_high     = req.key_high;
                            entries[s].surname_low  = req.surname_low;
                            entries[s].surname_high = req.surname_high;
                            entries[s].phone_low    = req.phone_low;
                            entries[s].phone_high   = req.phone_high;
                            beat.status = ST_DONE;
                            beat.slot   = SLOT_W'(s);
                            placed      = 1'b1;
                        end
                    end
                    pending_q.push_back(beat);
                end
                OP_DELETE: begin
                    // an empty name matches nothing
                    for (s = 0; s < TABLE_DEPTH; s++) begin
                        if (!key_zero && entries[s].key_low == req.key_low &&
                            entries[s].key_high == req.key_high) begin
                            entries[s] = '0;
                            removed++;
                        end
                    end
                    if (removed == 0) begin
                        beat.status = ST_NONE;
                    end else begin
                        beat.status        = ST_DONE;
                        beat.removed_count = CNT_W'(removed);
                    end
                    pending_q.push_back(beat);
                end
                default: begin
                    // search and list: one beat per hit, last on the final one
                    for (s = 0; s < TABLE_DEPTH; s++) begin
                        if (req.operation == OP_SEARCH)
                            hit = !key_zero && entries[s].key_low == req.key_low &&
                                  entries[s].key_high == req.key_high;
                        else
                            hit = occupied(s);
                        if (hit) begin
                            if (have_held) pending_q.push_back(held);
                            held                  = '0;
                            held.status           = ST_EMIT;
                            held.slot             = SLOT_W'(s);
                            held.out_key_low      = entries[s].key_low;
                            held.out_key_high     = entries[s].key_high;
                            held.out_surname_low  = entries[s].surname_low;
                            held.out_surname_high = entries[s].surname_high;
                            held.out_phone_low    = entries[s].phone_low;
                            held.out_phone_high   = entries[s].phone_high;
                            have_held             = 1'b1;
                        end
                    end
                    if (have_held) begin
                        held.last = 1'b1;
                        pending_q.push_back(held);
                    end else begin
                        beat.status = ST_NONE;
                        pending_q.push_back(beat);
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, logic [LOW_W-1:0] want_v,
                                    logic [LOW_W-1:0] got_v);
            if (got_v !== want_v) begin
                $error("%s: expected %0h, got %0h", name, want_v, got_v);
                errors++;
            end
        endfunction

        // Compare one result beat against the oldest pending one
        function void check_result(t_out got);
            t_out want;
            if (pending_q.size() == 0) begin
                $error("result beat with nothing pending: status %0d slot %0d",
                       got.status, got.slot);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            beats_checked++;
            compare_field("status", LOW_W'(want.status), LOW_W'(got.status));
            compare_field("slot", LOW_W'(want.slot), LOW_W'(got.slot));
            compare_field("removed_count", LOW_W'(want.removed_count),
                          LOW_W'(got.removed_count));
            compare_field("out_key_low", want.out_key_low, got.out_key_low);
            compare_field("out_key_high", LOW_W'(want.out_key_high),
                          LOW_W'(got.out_key_high));
            compare_field("out_surname_low", want.out_surname_low, got.out_surname_low);
            compare_field("out_surname_high", LOW_W'(want.out_surname_high),
                          LOW_W'(got.out_surname_high));
            compare_field("out_phone_low", want.out_phone_low, got.out_phone_low);
            compare_field("out_phone_high", LOW_W'(want.out_phone_high),
                          LOW_W'(got.out_phone_high));
            compare_field("last", LOW_W'(want.last), LOW_W'(got.last));
            case (want.status)
                ST_EMIT: emitted++;
                ST_FULL: full_hits++;
                ST_NONE: miss_hits++;
                default: begin
                    if (32'(want.removed_count) > max_removed)
                        max_removed = 32'(want.removed_count);
                end
            endcase
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    t_in               in_beat;
    logic              out_valid;
    logic              out_stall;
    t_out              out_beat;
    int unsigned       send_idle_pct;
    int unsigned       recv_idle_pct;
    bit                hold_request;
    logic [LOW_W-1:0]  pool_low[NAME_POOL];
    logic [HIGH_W-1:0] pool_high[NAME_POOL];
    record_book        book = new();

    record_table_match_insert_delete dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Small set of names so that searches and deletes hit often
    task automatic refresh_names();
        foreach (pool_low[i]) begin
            pool_low[i]  = {$urandom, $urandom};
            pool_high[i] = HIGH_W'($urandom);
        end
        // one name with an empty low part, one with an empty high part
        pool_low[0]  = '0;
        pool_high[1] = '0;
        if (pool_high[0] == '0) pool_high[0] = HIGH_W'(1);
    endtask

    function automatic t_in random_request();
        t_in         req;
        int unsigned pick;
        int unsigned idx;
        pick = $urandom_range(99);
        if (pick < 40)      req.operation = OP_INSERT;
        else if (pick < 55) req.operation = OP_DELETE;
        else if (pick < 80) req.operation = OP_SEARCH;
        else                req.operation = OP_LIST;
        pick = $urandom_range(99);
        idx  = $urandom_range(NAME_POOL - 1);
        if (pick < 8) begin
            req.key_low  = '0;
            req.key_high = '0;
        end else if (pick < 20) begin
            req.key_low  = {$urandom, $urandom};
            req.key_high = HIGH_W'($urandom);
        end else begin
            req.key_low  = pool_low[idx];
            req.key_high = pool_high[idx];
        end
        req.surname_low  = {$urandom, $urandom};
        req.surname_high = HIGH_W'($urandom);
        req.phone_low    = {$urandom, $urandom};
        req.phone_high   = HIGH_W'($urandom);
        return req;
    endfunction

    // Offer one beat, idling first at the current rate; note it once taken
    task automatic send_request(input t_in req);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= req;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        book.take_request(req);
    endtask

    // Named operation; surname and phone all ones or random
    task automatic send_op(input t_op op, input logic [LOW_W-1:0] kl,
                           input logic [HIGH_W-1:0] kh, input bit ones_rest);
        t_in req;
        req = random_request();
        req.operation = op;
        req.key_low   = kl;
        req.key_high  = kh;
        if (ones_rest) begin
            req.surname_low  = '1;
            req.surname_high = '1;
            req.phone_low    = '1;
            req.phone_high   = '1;
        end
        send_request(req);
    endtask

    // Result side: check accepted beats, stall at random or for a long hold-off
    initial begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall) book.check_result(out_beat);
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                out_stall   <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial begin : stimulus
        t_in               req;
        int                slot_idx;
        int unsigned       idx;
        logic [LOW_W-1:0]  fill_low;
        logic [HIGH_W-1:0] fill_high;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_beat       = '0;
        hold_request  = 1'b0;
        send_idle_pct = 12;
        recv_idle_pct = 84;
        refresh_names();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: list, empty-name search and delete, plain miss
        send_op(OP_LIST, '0, '0, 1'b0);
        send_op(OP_SEARCH, '0, '0, 1'b0);
        send_op(OP_DELETE, '0, '0, 1'b0);
        send_op(OP_SEARCH, pool_low[2], pool_high[2], 1'b0);
        // all-ones record, then names with only one half set
        send_op(OP_INSERT, '1, '1, 1'b1);
        send_op(OP_INSERT, pool_low[0], pool_high[0], 1'b0);
        send_op(OP_INSERT, pool_low[1], pool_high[1], 1'b0);
        // empty name is written but its slot stays free
        send_op(OP_INSERT, '0, '0, 1'b1);
        send_op(OP_INSERT, pool_low[2], pool_high[2], 1'b0);
        send_op(OP_INSERT, pool_low[2], pool_high[2], 1'b0);
        send_op(OP_LIST, '0, '0, 1'b0);
        send_op(OP_SEARCH, pool_low[2], pool_high[2], 1'b0);
        send_op(OP_SEARCH, '1, '1, 1'b1);
        // same low part, different high part: no match
        send_op(OP_SEARCH, pool_low[2], ~pool_high[2], 1'b0);
        send_op(OP_DELETE, pool_low[2], ~pool_high[2], 1'b0);
        send_op(OP_DELETE, pool_low[2], pool_high[2], 1'b0);
        send_op(OP_SEARCH, pool_low[2], pool_high[2], 1'b0);
        send_op(OP_DELETE, '0, '0, 1'b1);
        send_op(OP_INSERT, pool_low[3], pool_high[3], 1'b0);
        send_op(OP_SEARCH, pool_low[0], pool_high[0], 1'b1);
        send_op(OP_LIST, '0, '0, 1'b1);

        // busy sender, heavily stalled sink
        repeat (120) send_request(random_request());

        // busy sink, sparse sender
        send_idle_pct = 84;
        recv_idle_pct = 12;
        refresh_names();
        repeat (120) send_request(random_request());

        // no idling; sink holds off while inserts pile up and fill the table
        send_idle_pct = 0;
        recv_idle_pct = 0;
        refresh_names();
        hold_request = 1'b1;
        repeat (70) begin
            req           = random_request();
            idx           = $urandom_range(NAME_POOL - 1);
            req.operation = OP_INSERT;
            req.key_low   = pool_low[idx];
            req.key_high  = pool_high[idx];
            send_request(req);
        end
        send_op(OP_LIST, '0, '0, 1'b0);

        // empty the table name by name
        for (slot_idx = book.lowest_used(); slot_idx >= 0; slot_idx = book.lowest_used())
            send_op(OP_DELETE, book.entries[slot_idx].key_low,
                    book.entries[slot_idx].key_high, 1'b0);

        // one name in every slot: full, search hits everywhere, delete clears all
        fill_low  = {$urandom, $urandom} | 64'h1;
        fill_high = HIGH_W'($urandom);
        repeat (TABLE_DEPTH + 1) send_op(OP_INSERT, fill_low, fill_high, 1'b0);
        send_op(OP_SEARCH, fill_low, fill_high, 1'b0);
        send_op(OP_LIST, '0, '0, 1'b0);
        send_op(OP_DELETE, fill_low, fill_high, 1'b0);
        send_op(OP_LIST, '0, '0, 1'b0);

        repeat (20) send_request(random_request());
        in_valid <= 1'b0;

        // drain, then allow one full scan for stray beats
        while (book.pending_q.size() != 0) @(posedge clk);
        repeat (TABLE_DEPTH + 8) @(posedge clk);

        $display("summary: %0d operations applied, %0d result beats compared",
                 book.ops_taken, book.beats_checked);
        $display("summary: %0d records emitted, %0d table-full, %0d not-found, largest delete %0d",
                 book.emitted, book.full_hits, book.miss_hits, book.max_removed);
        if (book.errors == 0 && book.pending_q.size() == 0)
            $display("tb_record_table_match_insert_delete: done, clean");
        else
            $display("tb_record_table_match_insert_delete: done, errors");
        $finish;
    end

    // Hard stop if the handshakes hang
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("tb_record_table_match_insert_delete: done, errors");
        $finish;
    end

endmodule
